/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CSEH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define CSEH_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/cseh_pkg.sv */
package cseh_pkg;

  localparam int ROW_BITS_DEF    = 4;
  localparam int COL_BITS_DEF    = 4;
  localparam int EVICT_AFTER_DEF = 16;

  localparam int COORD_W     = 4;
  localparam int COORD_MAX_W = 8;
  localparam int FRAME_W     = 16;
  localparam int SCORE_W     = 16;
  localparam int CNT_W       = 8;
  localparam int SEEN_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 32;

  localparam logic [SCORE_W-1:0] Q_ONE      = 16'd32768;
  localparam logic [SCORE_W-1:0] W_MIN      = 16'd328;
  localparam logic [SCORE_W-1:0] ROUND_HALF = 16'd16384;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 8'd255;
  localparam logic [SEEN_W-1:0]  SEEN_MAX   = 9'd511;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVOKE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CNEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RNEED   = 3'd6;

  localparam logic                 RST_SMOOTH = 1'b1;
  localparam logic [SCORE_W-1:0]   RST_WEIGHT = 16'd16384;
  localparam logic [SCORE_W-1:0]   RST_COMMIT = 16'd19661;
  localparam logic [SCORE_W-1:0]   RST_REVOKE = 16'd13107;
  localparam logic [CNT_W-1:0]     RST_WARMUP = 8'd3;
  localparam logic [CNT_W-1:0]     RST_CNEED  = 8'd2;
  localparam logic [CNT_W-1:0]     RST_RNEED  = 8'd2;

  typedef struct packed {
    logic               valid;
    logic               dot;
    logic [SCORE_W-1:0] ema;
    logic [CNT_W-1:0]   commit_cnt;
    logic [CNT_W-1:0]   revoke_cnt;
    logic [SEEN_W-1:0]  seen;
    logic [FRAME_W-1:0] last_frame;
  } entry_t;

  // Effective settings: weight already clamped, counts already at least one.
  typedef struct packed {
    logic               smoothing_enable;
    logic [SCORE_W-1:0] ema_weight;
    logic [SCORE_W-1:0] commit_level;
    logic [SCORE_W-1:0] revoke_level;
    logic [CNT_W-1:0]   warmup_count;
    logic [CNT_W-1:0]   commit_count_needed;
    logic [CNT_W-1:0]   revoke_count_needed;
  } cfg_t;

  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    at_least_one = (v == '0) ? CNT_W'(1) : v;
  endfunction

endpackage

/* sv/cseh_cfg_regs.sv */
module cseh_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cseh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cseh_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cseh_pkg::cfg_t                    cfg
);

  logic [cseh_pkg::SCORE_W-1:0] weight_clamped;
  logic [cseh_pkg::CNT_W-1:0]   count_fixed;

  always_comb begin
    if (cfg_data < cseh_pkg::W_MIN) begin
      weight_clamped = cseh_pkg::W_MIN;
    end else if (cfg_data > cseh_pkg::Q_ONE) begin
      weight_clamped = cseh_pkg::Q_ONE;
    end else begin
      weight_clamped = cfg_data;
    end
    count_fixed = cseh_pkg::at_least_one(cfg_data[cseh_pkg::CNT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_enable    <= cseh_pkg::RST_SMOOTH;
      cfg.ema_weight          <= cseh_pkg::RST_WEIGHT;
      cfg.commit_level        <= cseh_pkg::RST_COMMIT;
      cfg.revoke_level        <= cseh_pkg::RST_REVOKE;
      cfg.warmup_count        <= cseh_pkg::RST_WARMUP;
      cfg.commit_count_needed <= cseh_pkg::RST_CNEED;
      cfg.revoke_count_needed <= cseh_pkg::RST_RNEED;
    end else if (cfg_we) begin
      case (cfg_index)
        cseh_pkg::REG_SMOOTH: cfg.smoothing_enable    <= cfg_data[0];
        cseh_pkg::REG_WEIGHT: cfg.ema_weight          <= weight_clamped;
        cseh_pkg::REG_COMMIT: cfg.commit_level        <= cfg_data;
        cseh_pkg::REG_REVOKE: cfg.revoke_level        <= cfg_data;
        cseh_pkg::REG_WARMUP: cfg.warmup_count        <= count_fixed;
        cseh_pkg::REG_CNEED:  cfg.commit_count_needed <= count_fixed;
        cseh_pkg::REG_RNEED:  cfg.revoke_count_needed <= count_fixed;
        default: ;
      endcase
    end
  end

endmodule

/* sv/cseh_cell_table.sv */
module cseh_cell_table #(
  parameter int IDX_W = cseh_pkg::ROW_BITS_DEF + cseh_pkg::COL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output cseh_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  cseh_pkg::entry_t     wr_data,
  output logic                 busy
);

  localparam int DEPTH = 1 << IDX_W;

  cseh_pkg::entry_t mem [DEPTH];
  logic [IDX_W-1:0] clr_addr;

  // After reset every entry is written once with a cleared valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == {IDX_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/cseh_cell_update.sv */
module cseh_cell_update #(
  parameter int EVICT_AFTER = cseh_pkg::EVICT_AFTER_DEF
) (
  input  cseh_pkg::cfg_t                cfg,
  input  cseh_pkg::entry_t              cur,
  input  logic [cseh_pkg::FRAME_W-1:0]  frame,
  input  logic [cseh_pkg::SCORE_W-1:0]  raw,
  output cseh_pkg::entry_t              nxt,
  output logic                          dot,
  output logic [cseh_pkg::SCORE_W-1:0]  score
);

  logic [cseh_pkg::FRAME_W-1:0] age;
  logic                         fresh;
  logic [cseh_pkg::SEEN_W-1:0]  seen_inc;
  logic [cseh_pkg::CNT_W-1:0]   commit_inc;
  logic [cseh_pkg::CNT_W-1:0]   revoke_inc;
  logic signed [17:0]           diff;
  logic signed [34:0]           prod;
  logic signed [34:0]           step;
  logic signed [17:0]           ema_sum;
  logic [cseh_pkg::SCORE_W-1:0] ema_new;
  logic                         raw_hit;
  logic                         commit_hit;
  logic                         revoke_hit;
  logic                         in_warmup;

  // The blend w*raw + (1-w)*ema is computed as ema + w*(raw-ema); the
  // arithmetic shift floors exactly like the unsigned form does.
  always_comb begin
    age        = frame - cur.last_frame;
    fresh      = !cur.valid || (age > cseh_pkg::FRAME_W'(EVICT_AFTER));
    seen_inc   = (cur.seen == cseh_pkg::SEEN_MAX) ? cur.seen
                                                  : cur.seen + cseh_pkg::SEEN_W'(1);
    commit_inc = (cur.commit_cnt == cseh_pkg::CNT_MAX) ? cur.commit_cnt
                                                       : cur.commit_cnt + cseh_pkg::CNT_W'(1);
    revoke_inc = (cur.revoke_cnt == cseh_pkg::CNT_MAX) ? cur.revoke_cnt
                                                       : cur.revoke_cnt + cseh_pkg::CNT_W'(1);
    diff       = $signed({2'b00, raw}) - $signed({2'b00, cur.ema});
    prod       = $signed({1'b0, cfg.ema_weight}) * diff;
    step       = (prod + $signed({19'd0, cseh_pkg::ROUND_HALF})) >>> 15;
    ema_sum    = $signed({2'b00, cur.ema}) + step[17:0];
    ema_new    = ema_sum[cseh_pkg::SCORE_W-1:0];
    raw_hit    = raw >= cfg.commit_level;
    commit_hit = ema_new >= cfg.commit_level;
    revoke_hit = ema_new <= cfg.revoke_level;
    in_warmup  = seen_inc <= {1'b0, cfg.warmup_count};

    nxt            = cur;
    nxt.last_frame = frame;
    if (fresh) begin
      nxt.valid      = 1'b1;
      nxt.ema        = raw;
      nxt.dot        = raw_hit;
      nxt.seen       = cseh_pkg::SEEN_W'(1);
      nxt.commit_cnt = raw_hit ? cfg.commit_count_needed : '0;
      nxt.revoke_cnt = raw_hit ? '0 : cfg.revoke_count_needed;
    end else begin
      nxt.seen = seen_inc;
      nxt.ema  = ema_new;
      if (in_warmup) begin
        nxt.dot = commit_hit;
      end else begin
        if (commit_hit) begin
          nxt.commit_cnt = commit_inc;
          nxt.revoke_cnt = '0;
        end else if (revoke_hit) begin
          nxt.revoke_cnt = revoke_inc;
          nxt.commit_cnt = '0;
        end else begin
          nxt.commit_cnt = '0;
          nxt.revoke_cnt = '0;
        end
        if (!cur.dot && (nxt.commit_cnt >= cfg.commit_count_needed)) begin
          nxt.dot = 1'b1;
        end else if (cur.dot && (nxt.revoke_cnt >= cfg.revoke_count_needed)) begin
          nxt.dot = 1'b0;
        end
      end
    end

    if (cfg.smoothing_enable) begin
      dot   = nxt.dot;
      score = nxt.ema;
    end else begin
      dot   = raw_hit;
      score = raw;
    end
  end

endmodule

/* sv/cell_score_ema_hysteresis_top.sv */
// Results: a request is read from the cell table into the s1 stage on acceptance, then
// updated and registered into the output stage, where m_tvalid rises; a stall holds s1.
// Throughput: one request per cycle while the output is not stalled; the table read and
// write-back with forwarding of the last written entry keep back-to-back requests to one
// cell correct. Reset: configuration takes its reset values and the cell table is cleared
// in one pass over all 2^(ROW_BITS+COL_BITS) entries (256 by default) while s_tready stays low.
module cell_score_ema_hysteresis_top #(
  parameter int ROW_BITS    = cseh_pkg::ROW_BITS_DEF,
  parameter int COL_BITS    = cseh_pkg::COL_BITS_DEF,
  parameter int EVICT_AFTER = cseh_pkg::EVICT_AFTER_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cell_row[3:0], cell_col[7:4], frame_number[23:8], obs_score[39:24]
  input  logic [cseh_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_row[3:0], out_col[7:4], dot_present[8], smoothed_score[24:9], zeros above
  output logic [cseh_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [cseh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cseh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = ROW_BITS + COL_BITS;

  cseh_pkg::cfg_t   cfg;
  cseh_pkg::entry_t rd_data;
  cseh_pkg::entry_t cur;
  cseh_pkg::entry_t nxt;
  cseh_pkg::entry_t fwd_entry;

  logic [cseh_pkg::COORD_MAX_W-1:0] row_ext;
  logic [cseh_pkg::COORD_MAX_W-1:0] col_ext;
  logic [IDX_W-1:0]                 in_idx;
  logic [cseh_pkg::SCORE_W-1:0]     raw_in;
  logic                             accept;
  logic                             advance;
  logic                             busy;
  logic                             wr_en;

  logic                             s1_valid;
  logic [IDX_W-1:0]                 s1_idx;
  logic [cseh_pkg::COORD_W-1:0]     s1_row;
  logic [cseh_pkg::COORD_W-1:0]     s1_col;
  logic [cseh_pkg::FRAME_W-1:0]     s1_frame;
  logic [cseh_pkg::SCORE_W-1:0]     s1_raw;

  logic                             fwd_valid;
  logic [IDX_W-1:0]                 fwd_idx;

  logic                             upd_dot;
  logic [cseh_pkg::SCORE_W-1:0]     upd_score;
  logic [cseh_pkg::COORD_W-1:0]     o_row;
  logic [cseh_pkg::COORD_W-1:0]     o_col;
  logic                             o_dot;
  logic [cseh_pkg::SCORE_W-1:0]     o_score;

  always_comb begin
    row_ext = {{(cseh_pkg::COORD_MAX_W - cseh_pkg::COORD_W){1'b0}}, s_tdata[3:0]};
    col_ext = {{(cseh_pkg::COORD_MAX_W - cseh_pkg::COORD_W){1'b0}}, s_tdata[7:4]};
    in_idx  = {row_ext[ROW_BITS-1:0], col_ext[COL_BITS-1:0]};
    raw_in  = (s_tdata[39:24] > cseh_pkg::Q_ONE) ? cseh_pkg::Q_ONE : s_tdata[39:24];
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !busy && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = advance && cfg.smoothing_enable;

  // The entry written in the cycle this request was read is not yet in the read data.
  assign cur = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_entry : rd_data;

  cseh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cseh_cell_table #(
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (nxt),
    .busy    (busy)
  );

  cseh_cell_update #(
    .EVICT_AFTER (EVICT_AFTER)
  ) u_update (
    .cfg   (cfg),
    .cur   (cur),
    .frame (s1_frame),
    .raw   (s1_raw),
    .nxt   (nxt),
    .dot   (upd_dot),
    .score (upd_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx   <= in_idx;
      s1_row   <= s_tdata[3:0];
      s1_col   <= s_tdata[7:4];
      s1_frame <= s_tdata[23:8];
      s1_raw   <= raw_in;
    end
    if (wr_en) begin
      fwd_idx   <= s1_idx;
      fwd_entry <= nxt;
    end
    if (advance) begin
      o_row   <= s1_row;
      o_col   <= s1_col;
      o_dot   <= upd_dot;
      o_score <= upd_score;
    end
  end

  assign m_tdata = {7'd0, o_score, o_dot, o_col, o_row};

endmodule

/* sv/cseh_checker.sv */
`include "assert_macros.svh"

module cseh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cseh_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] outstanding;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Requests taken in but not yet delivered; the block holds at most two.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `CSEH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `CSEH_ASSERT(a_no_orphan, outstanding == 2'd0 |-> !m_tvalid, "result without a request")
  `CSEH_ASSERT_NEVER(a_depth, outstanding == 2'd3, "more than two requests in flight")
  `CSEH_ASSERT(a_clear_pass, $past(rst) |-> !s_tready, "request taken before table clear")
  `CSEH_ASSERT(a_score_range, m_tvalid |-> m_tdata[24:9] <= 16'd32768, "score above one")

endmodule

bind cell_score_ema_hysteresis_top cseh_checker u_cseh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/cell_score_ema_hysteresis_top_tb.sv */
`timescale 1ns / 1ps

module cell_score_ema_hysteresis_top_tb;

  localparam logic [cseh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int TABLE_DEPTH = 1 << (cseh_pkg::ROW_BITS_DEF + cseh_pkg::COL_BITS_DEF);

  typedef enum logic [1:0] {OP_CELL, OP_REG, OP_DRAIN} op_kind_t;

  typedef struct packed {
    op_kind_t                        kind;
    logic [cseh_pkg::COORD_W-1:0]    row;
    logic [cseh_pkg::COORD_W-1:0]    col;
    logic [cseh_pkg::FRAME_W-1:0]    frame;
    logic [cseh_pkg::SCORE_W-1:0]    raw;
    logic [cseh_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [cseh_pkg::CFG_DATA_W-1:0] reg_val;
  } op_t;

  typedef struct packed {
    logic [cseh_pkg::COORD_W-1:0] row;
    logic [cseh_pkg::COORD_W-1:0] col;
    logic                         dot;
    logic [cseh_pkg::SCORE_W-1:0] score;
  } cell_decision_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [cseh_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [cseh_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic                              cfg_we = 1'b0;
  logic [cseh_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [cseh_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  cell_score_ema_hysteresis_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the block's registers and cell table.
  logic                         cfg_smooth  = cseh_pkg::RST_SMOOTH;
  logic [cseh_pkg::SCORE_W-1:0] cfg_weight  = cseh_pkg::RST_WEIGHT;
  logic [cseh_pkg::SCORE_W-1:0] cfg_commit  = cseh_pkg::RST_COMMIT;
  logic [cseh_pkg::SCORE_W-1:0] cfg_revoke  = cseh_pkg::RST_REVOKE;
  logic [cseh_pkg::CNT_W-1:0]   cfg_warmup  = cseh_pkg::RST_WARMUP;
  logic [cseh_pkg::CNT_W-1:0]   cfg_cneed   = cseh_pkg::RST_CNEED;
  logic [cseh_pkg::CNT_W-1:0]   cfg_rneed   = cseh_pkg::RST_RNEED;
  cseh_pkg::entry_t             cell_tbl [TABLE_DEPTH];

  op_t            pending_ops[$];
  cell_decision_t cell_decisions_due[$];

  int          items_accepted = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          cycle_no = 0;
  int          mismatches = 0;
  int          reg_writes = 0;
  int          reseeds = 0;
  int          dots_seen = 0;
  logic        all_sent = 1'b0;
  logic [cseh_pkg::FRAME_W-1:0] frame_ctr = 16'd65500;

  // A stretch of cycles in which neither side idles.
  wire no_idle = (cycle_no >= 300) && (cycle_no < 700);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= rst ? 0 : cycle_no + 1;
  end

  function automatic void apply_reg(input logic [cseh_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [cseh_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      cseh_pkg::REG_SMOOTH: cfg_smooth = val[0];
      cseh_pkg::REG_WEIGHT: cfg_weight = val;
      cseh_pkg::REG_COMMIT: cfg_commit = val;
      cseh_pkg::REG_REVOKE: cfg_revoke = val;
      cseh_pkg::REG_WARMUP: cfg_warmup = val[cseh_pkg::CNT_W-1:0];
      cseh_pkg::REG_CNEED:  cfg_cneed  = val[cseh_pkg::CNT_W-1:0];
      cseh_pkg::REG_RNEED:  cfg_rneed  = val[cseh_pkg::CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endfunction

  // Works out the decision for one observation and queues it.
  function automatic void decide_cell(input logic [cseh_pkg::COORD_W-1:0] row, col,
                                      input logic [cseh_pkg::FRAME_W-1:0] frame,
                                      input logic [cseh_pkg::SCORE_W-1:0] raw_in);
    logic [cseh_pkg::SCORE_W-1:0] raw;
    logic [cseh_pkg::SCORE_W-1:0] w;
    logic [cseh_pkg::CNT_W-1:0]   warm, cneed, rneed;
    logic [cseh_pkg::FRAME_W-1:0] age;
    logic [31:0]                  mix;
    logic                         fresh;
    cseh_pkg::entry_t             e;
    cell_decision_t               d;
    raw = (raw_in > cseh_pkg::Q_ONE) ? cseh_pkg::Q_ONE : raw_in;
    d.row = row;
    d.col = col;
    if (!cfg_smooth) begin
      d.dot = raw >= cfg_commit;
      d.score = raw;
    end else begin
      e = cell_tbl[{row, col}];
      if (cfg_weight < cseh_pkg::W_MIN) w = cseh_pkg::W_MIN;
      else if (cfg_weight > cseh_pkg::Q_ONE) w = cseh_pkg::Q_ONE;
      else w = cfg_weight;
      warm  = (cfg_warmup == '0) ? cseh_pkg::CNT_W'(1) : cfg_warmup;
      cneed = (cfg_cneed == '0) ? cseh_pkg::CNT_W'(1) : cfg_cneed;
      rneed = (cfg_rneed == '0) ? cseh_pkg::CNT_W'(1) : cfg_rneed;
      age = frame - e.last_frame;
      fresh = !e.valid || (age > cseh_pkg::EVICT_AFTER_DEF);
      e.last_frame = frame;
      if (fresh) begin
        reseeds++;
        e.valid = 1'b1;
        e.ema = raw;
        e.dot = raw >= cfg_commit;
        e.seen = cseh_pkg::SEEN_W'(1);
        e.commit_cnt = e.dot ? cneed : '0;
        e.revoke_cnt = e.dot ? '0 : rneed;
      end else begin
        e.seen = (e.seen == cseh_pkg::SEEN_MAX) ? cseh_pkg::SEEN_MAX : e.seen + 1'b1;
        mix = {16'd0, w} * {16'd0, raw} + (32'd32768 - {16'd0, w}) * {16'd0, e.ema}
              + {16'd0, cseh_pkg::ROUND_HALF};
        e.ema = mix[30:15];
        if ({1'b0, warm} >= e.seen) begin
          e.dot = e.ema >= cfg_commit;
        end else begin
          if (e.ema >= cfg_commit) begin
            e.commit_cnt = (e.commit_cnt == cseh_pkg::CNT_MAX) ? cseh_pkg::CNT_MAX
                                                                : e.commit_cnt + 1'b1;
            e.revoke_cnt = '0;
          end else if (e.ema <= cfg_revoke) begin
            e.revoke_cnt = (e.revoke_cnt == cseh_pkg::CNT_MAX) ? cseh_pkg::CNT_MAX
                                                                : e.revoke_cnt + 1'b1;
            e.commit_cnt = '0;
          end else begin
            e.commit_cnt = '0;
            e.revoke_cnt = '0;
          end
          if (!e.dot && e.commit_cnt >= cneed) begin
            e.dot = 1'b1;
          end else if (e.dot && e.revoke_cnt >= rneed) begin
            e.dot = 1'b0;
          end
        end
      end
      cell_tbl[{row, col}] = e;
      d.dot = e.dot;
      d.score = e.ema;
    end
    cell_decisions_due.insert(cell_decisions_due.size(), d);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [cseh_pkg::SCORE_W-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: presents queued observations and performs register writes when idle.
  always @(posedge clk) begin
    logic                            acc;
    logic                            nv;
    logic                            nwe;
    logic                            nsent;
    logic [cseh_pkg::IN_DATA_W-1:0]  nd;
    logic [cseh_pkg::CFG_IDX_W-1:0]  nidx;
    logic [cseh_pkg::CFG_DATA_W-1:0] ndata;
    op_t                             head;
    nv = 1'b0;
    nwe = 1'b0;
    nsent = all_sent;
    nd = s_tdata;
    nidx = cfg_index;
    ndata = cfg_data;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      acc = s_tvalid && s_tready;
      if (acc) begin
        head = pending_ops.pop_front();
        decide_cell(head.row, head.col, head.frame, head.raw);
        items_accepted++;
      end
      if (items_accepted == results_seen) quiet_cycles++;
      else quiet_cycles = 0;
      if (pending_ops.size() == 0) begin
        nsent = 1'b1;
      end else begin
        head = pending_ops[0];
        case (head.kind)
          OP_CELL: begin
            if (s_tvalid && !acc) begin
              nv = 1'b1;
            end else if (no_idle || $urandom_range(99) >= 9) begin
              nv = 1'b1;
              nd = {head.raw, head.frame, head.col, head.row};
            end
          end
          OP_REG: begin
            if (quiet_cycles >= 3 && s_tready) begin
              nwe = 1'b1;
              nidx = head.reg_idx;
              ndata = head.reg_val;
              apply_reg(head.reg_idx, head.reg_val);
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 1) void'(pending_ops.pop_front());
          end
        endcase
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
    cfg_we <= nwe;
    cfg_index <= nidx;
    cfg_data <= ndata;
    all_sent <= nsent;
  end

  // Result monitor.
  always @(posedge clk) begin
    cell_decision_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cell_decisions_due.size() == 0) begin
        $error("result with no request waiting: %h", m_tdata);
        mismatches++;
      end else begin
        want = cell_decisions_due.pop_front();
        check_field("out_row", cseh_pkg::SCORE_W'(want.row), cseh_pkg::SCORE_W'(m_tdata[3:0]));
        check_field("out_col", cseh_pkg::SCORE_W'(want.col), cseh_pkg::SCORE_W'(m_tdata[7:4]));
        check_field("dot_present", cseh_pkg::SCORE_W'(want.dot),
                    cseh_pkg::SCORE_W'(m_tdata[8]));
        check_field("smoothed_score", want.score, m_tdata[24:9]);
        check_field("padding", '0,
                    cseh_pkg::SCORE_W'(m_tdata[cseh_pkg::OUT_DATA_W-1:25]));
        if (m_tdata[8]) dots_seen++;
      end
      results_seen <= results_seen + 1;
    end
    m_tready <= !rst && (no_idle || $urandom_range(99) >= 9);
  end

  task automatic add_cell(input logic [cseh_pkg::COORD_W-1:0] row, col,
                          input logic [cseh_pkg::FRAME_W-1:0] frame,
                          input logic [cseh_pkg::SCORE_W-1:0] raw);
    op_t op;
    op = '0;
    op.kind = OP_CELL;
    op.row = row;
    op.col = col;
    op.frame = frame;
    op.raw = raw;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_reg(input logic [cseh_pkg::CFG_IDX_W-1:0] idx,
                         input logic [cseh_pkg::CFG_DATA_W-1:0] val);
    op_t op;
    op = '0;
    op.kind = OP_REG;
    op.reg_idx = idx;
    op.reg_val = val;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_drain();
    op_t op;
    op = '0;
    op.kind = OP_DRAIN;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_settings(input logic [15:0] en, w, c, r, wu, cn, rn);
    add_reg(cseh_pkg::REG_SMOOTH, en);
    add_reg(cseh_pkg::REG_WEIGHT, w);
    add_reg(cseh_pkg::REG_COMMIT, c);
    add_reg(cseh_pkg::REG_REVOKE, r);
    add_reg(cseh_pkg::REG_WARMUP, wu);
    add_reg(cseh_pkg::REG_CNEED, cn);
    add_reg(cseh_pkg::REG_RNEED, rn);
  endtask

  // A few cells tracked frame after frame, each drifting between a present and an
  // absent score, with stray observations and frame jumps mixed in.
  task automatic add_frames(input int n);
    logic [cseh_pkg::COORD_W-1:0] frow [4];
    logic [cseh_pkg::COORD_W-1:0] fcol [4];
    logic                         high [4];
    logic [cseh_pkg::SCORE_W-1:0] raw;
    int                           made;
    int                           pick;
    for (int i = 0; i < 4; i++) begin
      frow[i] = cseh_pkg::COORD_W'($urandom);
      fcol[i] = cseh_pkg::COORD_W'($urandom);
      high[i] = 1'($urandom_range(1));
    end
    made = 0;
    while (made < n) begin
      pick = $urandom_range(19);
      if (pick == 0) frame_ctr = frame_ctr + 16'($urandom_range(40, 17));
      else if (pick != 1) frame_ctr = frame_ctr + 16'd1;
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(5) == 0) high[i] = !high[i];
        pick = $urandom_range(9);
        if (pick == 0) begin
          add_cell(cseh_pkg::COORD_W'($urandom), cseh_pkg::COORD_W'($urandom),
                   16'($urandom), 16'($urandom));
        end else begin
          if (pick == 1) raw = 16'($urandom_range(22000, 11000));
          else if (high[i]) raw = 16'($urandom_range(32768, 22000));
          else raw = 16'($urandom_range(11000, 0));
          add_cell(frow[i], fcol[i], frame_ctr, raw);
        end
        made++;
      end
    end
  endtask

  initial begin
    logic [15:0] lvl;
    for (int i = 0; i < TABLE_DEPTH; i++) cell_tbl[i] = '0;

    // Seeding absent, then warmup, during which the dot commits once the smoothed score reaches the level.
    add_cell(4'd0, 4'd0, 16'd0, 16'd0);
    for (int f = 1; f <= 5; f++) add_cell(4'd0, 4'd0, 16'(f), 16'd32768);
    // The same frame twice, then a gap long enough to age the entry out.
    add_cell(4'd0, 4'd0, 16'd5, 16'd32768);
    add_cell(4'd0, 4'd0, 16'd22, 16'd0);
    // Saturated raw score; an age of exactly the eviction limit keeps the entry.
    add_cell(4'd15, 4'd15, 16'd100, 16'hFFFF);
    add_cell(4'd15, 4'd15, 16'd116, 16'd0);
    add_cell(4'd15, 4'd15, 16'd133, 16'd0);
    // Frame number wrapping around.
    add_cell(4'd3, 4'd5, 16'd65530, 16'd20000);
    add_cell(4'd3, 4'd5, 16'd4, 16'd0);
    add_cell(4'd8, 4'd1, 16'd7, 16'd19661);
    add_cell(4'd8, 4'd1, 16'd8, 16'd13107);
    add_drain();
    // Stateless mode; the written value has its low bit clear.
    add_reg(cseh_pkg::REG_SMOOTH, 16'hFFFE);
    add_cell(4'd1, 4'd2, 16'd9, 16'd0);
    add_cell(4'd1, 4'd2, 16'd9, 16'd19660);
    add_cell(4'd1, 4'd2, 16'd9, 16'd19661);
    add_cell(4'd1, 4'd2, 16'd9, 16'hFFFF);
    add_reg(REG_UNUSED, 16'h0000);
    // Weight below the clamp and zero counts, which act as one.
    add_settings(16'h0001, 16'd0, 16'd0, 16'd32768, 16'hFF00, 16'd0, 16'd0);
    add_cell(4'd2, 4'd2, 16'd50, 16'd1000);
    add_cell(4'd2, 4'd2, 16'd51, 16'd30000);
    add_cell(4'd2, 4'd2, 16'd52, 16'd0);
    add_reg(cseh_pkg::REG_WEIGHT, 16'hFFFF);
    add_cell(4'd2, 4'd2, 16'd53, 16'd32768);
    add_cell(4'd2, 4'd2, 16'd54, 16'd100);

    for (int p = 0; p < 6; p++) begin
      add_drain();
      case (p)
        0: add_settings(16'd1, cseh_pkg::RST_WEIGHT, cseh_pkg::RST_COMMIT,
                        cseh_pkg::RST_REVOKE, 16'd3, 16'd2, 16'd2);
        1: add_settings(16'd1, 16'd32768, 16'd16384, 16'd16384, 16'd1, 16'd1, 16'd1);
        2: add_settings(16'd1, 16'd328, 16'd32768, 16'd0, 16'd255, 16'd255, 16'd255);
        3: add_settings(16'd0, 16'($urandom), 16'($urandom_range(32768)),
                        16'($urandom_range(32768)), 16'($urandom_range(255, 1)),
                        16'($urandom_range(255, 1)), 16'($urandom_range(255, 1)));
        default: begin
          lvl = 16'($urandom_range(26000, 16000));
          add_settings(16'd1, 16'($urandom_range(32768, 328)), lvl,
                       16'($urandom_range(lvl, 6000)), 16'($urandom_range(6, 1)),
                       16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)));
        end
      endcase
      add_frames(72);
    end
    add_drain();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (all_sent);
    repeat (8) @(posedge clk);
    #1;
    if (cell_decisions_due.size() != 0) begin
      $error("%0d results never arrived", cell_decisions_due.size());
      mismatches++;
    end
    $display("Covered %0d cell observations across %0d register writes,", items_accepted,
             reg_writes);
    $display("smoothed and stateless, with %0d seeds or reseeds and %0d dot results.",
             reseeds, dots_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
